>>> src/assert_macros.svh
// assertion macros shared by the rolling hash store rtl
// no dependencies; expects a clock named clock and a reset named reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every rising edge outside reset
`define PRH_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);
// expression must never be true outside reset
`define PRH_NEVER(lbl, expr, msg) \
   `PRH_ASSERT(lbl, !(expr), msg)
`endif

>>> src/prh_pkg.sv
// package of the rolling hash store: constants, codes, payload and state types
// no dependencies
`default_nettype none
package prh_pkg;

   localparam int unsigned MAX_LENGTH_DEFAULT = 1024;
   localparam int unsigned HASH_W = 30;
   localparam int unsigned BASE_W = 20;
   localparam int unsigned ELEM_W = 32;
   localparam int unsigned IDX_W  = 10;
   localparam logic [HASH_W-1:0] HASH_PRIME = 30'd998244353;
   localparam logic [BASE_W-1:0] BASE_RESET = 20'd257;

   localparam logic [2:0] CMD_CLEAR    = 3'd0;
   localparam logic [2:0] CMD_APPEND   = 3'd1;
   localparam logic [2:0] CMD_RANGE    = 3'd2;
   localparam logic [2:0] CMD_KEY      = 3'd3;
   localparam logic [2:0] CMD_CONTAINS = 3'd4;
   localparam logic [2:0] CMD_OVERLAP  = 3'd5;
   localparam logic [2:0] CMD_PREFIX   = 3'd6;
   localparam logic [2:0] CMD_SUFFIX   = 3'd7;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam logic REG_HASH_BASE = 1'b0;

   typedef struct packed {
      logic [2:0]        command;
      logic              bank;
      logic [ELEM_W-1:0] element_value;
      logic [IDX_W-1:0]  range_start;
      logic [IDX_W-1:0]  range_end;
   } req_type;

   typedef struct packed {
      logic [HASH_W-1:0] result_value;
      logic [1:0]        status;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISP, ST_RED, ST_PW_RD, ST_PW_WR, ST_H_START, ST_H_RD, ST_H_ADD,
      ST_H_WR, ST_MUL, ST_SP0, ST_SP1, ST_SP2, ST_SP3, ST_RG_FIN, ST_CT_KEY,
      ST_CT_CHK, ST_OV_B, ST_OV_CHK, ST_BS_TOP, ST_BS_B, ST_BS_CHK, ST_RESP
   } state_type;

endpackage
`default_nettype wire

>>> src/prh_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module prh_ram #(
   parameter int unsigned WIDTH = 30,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [WIDTH-1:0]     wdata,
   input  wire logic [AW-1:0]        raddr,
   output logic      [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

>>> src/prh_mulmod.sv
// bit-serial modular multiplier, one multiplier bit per cycle
// depends on prh_pkg
`default_nettype none
module prh_mulmod (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [prh_pkg::HASH_W-1:0] a,
   input  wire logic [prh_pkg::HASH_W-1:0] b,
   output logic                            busy,
   output logic      [prh_pkg::HASH_W-1:0] product
);
   localparam int unsigned W = prh_pkg::HASH_W;
   localparam logic [4:0] LAST = 5'(W - 1);

   logic [W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic [W:0]   dbl, sum;
   logic [W-1:0] dbl_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, prh_pkg::HASH_PRIME}) ?
                W'(dbl - {1'b0, prh_pkg::HASH_PRIME}) : W'(dbl);
      sum     = {1'b0, dbl_red} + (b_ff[W-1] ? {1'b0, a_ff} : '0);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = (sum >= {1'b0, prh_pkg::HASH_PRIME}) ?
                  W'(sum - {1'b0, prh_pkg::HASH_PRIME}) : W'(sum);
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

>>> src/polynomial_rolling_hash_store.sv
// from input transfer to result valid: clear goes straight to the response, key hashes one
// prefix span, range hash runs one span with or without a multiply, append reduces the element
// (up to four reductions) and runs up to two passes of the serial multiply; contains takes one
// span per position, overlap two per length tried, common prefix/suffix two per search step;
// input stalled until the result loads; synchronous reset empties both banks and sets the base
// to 257, with no clearing pass; depends on prh_pkg, prh_ram, prh_mulmod and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module polynomial_rolling_hash_store #(
   parameter int unsigned MAX_LENGTH = prh_pkg::MAX_LENGTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire prh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output prh_pkg::rsp_type      rsp_data,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready
);
   localparam int unsigned W  = prh_pkg::HASH_W;
   localparam int unsigned LW = $clog2(MAX_LENGTH + 1);
   localparam int unsigned BW = LW + 1;
   localparam int unsigned AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int unsigned CW = (LW > prh_pkg::IDX_W) ? LW : prh_pkg::IDX_W;
   localparam logic [LW-1:0] ONE = LW'(1);

   prh_pkg::state_type state_ff, state_in, sret_ff, sret_in, mret_ff, mret_in;

   logic [prh_pkg::BASE_W-1:0] base_ff, base_in;
   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in, filled_ff, filled_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic          sel_ff, sel_in, sp_bank_ff, sp_bank_in;
   logic [31:0]   er_ff, er_in;
   logic [prh_pkg::IDX_W-1:0] rs_ff, rs_in, re_ff, re_in;
   logic [LW-1:0] n_ff, n_in, m_ff, m_in, cnt_ff, cnt_in, sp_l_ff, sp_l_in;
   logic [LW-1:0] sp_r_ff, sp_r_in, mid_ff, mid_in;
   logic [BW-1:0] lo_ff, lo_in, hi_ff, hi_in, ans_ff, ans_in;
   logic [W-1:0]  hr_ff, hr_in, span_ff, span_in, val1_ff, val1_in, hv_ff, hv_in;
   logic [W-1:0]  res_ff, res_in;
   logic [1:0]    st_ff, st_in;
   logic          rsp_valid_ff, rsp_valid_in;
   prh_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          pw_we, ha_we, hb_we;
   logic [AW-1:0] pw_wa, pw_ra, h_wa, h_ra;
   logic [W-1:0]  pw_wd, h_wd, pw_rd, ha_rd, hb_rd, h_rd;
   logic          mul_start, mul_busy;
   logic [W-1:0]  mul_a, mul_b, mul_p;

   logic          cfg_write;
   logic [LW-1:0] mn, lm1, plen, mid_w;
   logic [BW:0]   lohi;
   logic [W:0]    hsum;

   prh_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_pw_ram (
      .clock(clock), .we(pw_we), .waddr(pw_wa), .wdata(pw_wd), .raddr(pw_ra), .rdata(pw_rd)
   );
   prh_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_ha_ram (
      .clock(clock), .we(ha_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(ha_rd)
   );
   prh_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_hb_ram (
      .clock(clock), .we(hb_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(hb_rd)
   );
   prh_mulmod u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .busy(mul_busy), .product(mul_p)
   );

   assign cfg_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[2] == prh_pkg::REG_HASH_BASE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == prh_pkg::REG_HASH_BASE) ? 32'(base_ff) : '0;
   assign req_stall  = (state_ff != prh_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign h_rd  = sp_bank_ff ? hb_rd : ha_rd;
   assign mn    = (n_ff < m_ff) ? n_ff : m_ff;
   assign lm1   = sp_l_ff - ONE;
   assign plen  = sp_r_ff - sp_l_ff + ONE;
   assign lohi  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_w = LW'(lohi[BW:1]);
   assign hsum  = {1'b0, mul_p} + {1'b0, er_ff[W-1:0]};

   function automatic logic [AW-1:0] lm1_of_n(input logic [LW-1:0] v);
      logic [LW-1:0] t;
      t = v - ONE;
      return t[AW-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prh_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sret_in = sret_ff; mret_in = mret_ff;
      base_in = base_ff; len_a_in = len_a_ff; len_b_in = len_b_ff; filled_in = filled_ff;
      cmd_in = cmd_ff; sel_in = sel_ff; sp_bank_in = sp_bank_ff; er_in = er_ff;
      rs_in = rs_ff; re_in = re_ff; n_in = n_ff; m_in = m_ff; cnt_in = cnt_ff;
      sp_l_in = sp_l_ff; sp_r_in = sp_r_ff; mid_in = mid_ff;
      lo_in = lo_ff; hi_in = hi_ff; ans_in = ans_ff;
      hr_in = hr_ff; span_in = span_ff; val1_in = val1_ff; hv_in = hv_ff;
      res_in = res_ff; st_in = st_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      pw_we = 1'b0; ha_we = 1'b0; hb_we = 1'b0;
      pw_wa = n_ff[AW-1:0]; pw_wd = '0; pw_ra = '0;
      h_wa = n_ff[AW-1:0]; h_wd = hv_ff; h_ra = '0;
      mul_start = 1'b0; mul_a = h_rd; mul_b = W'(base_ff);

      if (cfg_write) begin
         base_in = csr_pwdata[prh_pkg::BASE_W-1:0];
         len_a_in = '0; len_b_in = '0; filled_in = '0;
      end

      unique case (state_ff)
         prh_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data.command;
               sel_in = req_data.bank;
               sp_bank_in = req_data.bank;
               er_in = req_data.element_value;
               rs_in = req_data.range_start;
               re_in = req_data.range_end;
               n_in = req_data.bank ? len_b_ff : len_a_ff;
               m_in = req_data.bank ? len_a_ff : len_b_ff;
               state_in = prh_pkg::ST_DISP;
            end
         end
         prh_pkg::ST_DISP: begin
            res_in = '0;
            st_in = prh_pkg::STATUS_OK;
            state_in = prh_pkg::ST_RESP;
            unique case (cmd_ff)
               prh_pkg::CMD_CLEAR: begin
                  if (sel_ff) len_b_in = '0;
                  else len_a_in = '0;
               end
               prh_pkg::CMD_APPEND: begin
                  if (32'(n_ff) >= 32'(MAX_LENGTH)) st_in = prh_pkg::STATUS_FULL;
                  else state_in = prh_pkg::ST_RED;
               end
               prh_pkg::CMD_RANGE: begin
                  if (rs_ff > re_ff || CW'(re_ff) >= CW'(n_ff)) begin
                     st_in = prh_pkg::STATUS_RANGE;
                  end else begin
                     sp_bank_in = sel_ff; sp_l_in = LW'(rs_ff); sp_r_in = LW'(re_ff);
                     sret_in = prh_pkg::ST_RG_FIN; state_in = prh_pkg::ST_SP0;
                  end
               end
               prh_pkg::CMD_KEY: begin
                  if (n_ff != '0) begin
                     sp_bank_in = sel_ff; sp_l_in = '0; sp_r_in = n_ff - ONE;
                     sret_in = prh_pkg::ST_RG_FIN; state_in = prh_pkg::ST_SP0;
                  end
               end
               prh_pkg::CMD_CONTAINS: begin
                  if (m_ff == '0) begin
                     res_in = W'(1);
                  end else if (n_ff >= m_ff) begin
                     sp_bank_in = !sel_ff; sp_l_in = '0; sp_r_in = m_ff - ONE;
                     sret_in = prh_pkg::ST_CT_KEY; state_in = prh_pkg::ST_SP0;
                  end
               end
               prh_pkg::CMD_OVERLAP: begin
                  if (mn != '0) begin
                     cnt_in = mn;
                     sp_bank_in = !sel_ff; sp_l_in = '0; sp_r_in = mn - ONE;
                     sret_in = prh_pkg::ST_OV_B; state_in = prh_pkg::ST_SP0;
                  end
               end
               default: begin
                  lo_in = '0; hi_in = BW'(mn); ans_in = '0;
                  state_in = prh_pkg::ST_BS_TOP;
               end
            endcase
         end
         prh_pkg::ST_RED: begin
            if (er_ff >= 32'(prh_pkg::HASH_PRIME)) begin
               er_in = er_ff - 32'(prh_pkg::HASH_PRIME);
            end else if (filled_ff <= n_ff) begin
               if (n_ff == '0) begin
                  pw_we = 1'b1; pw_wd = W'(1); filled_in = ONE;
                  state_in = prh_pkg::ST_H_START;
               end else begin
                  pw_ra = lm1_of_n(n_ff);
                  state_in = prh_pkg::ST_PW_RD;
               end
            end else begin
               state_in = prh_pkg::ST_H_START;
            end
         end
         prh_pkg::ST_PW_RD: begin
            mul_start = 1'b1; mul_a = pw_rd;
            mret_in = prh_pkg::ST_PW_WR; state_in = prh_pkg::ST_MUL;
         end
         prh_pkg::ST_PW_WR: begin
            pw_we = 1'b1; pw_wd = mul_p; filled_in = n_ff + ONE;
            state_in = prh_pkg::ST_H_START;
         end
         prh_pkg::ST_H_START: begin
            if (n_ff == '0) begin
               hv_in = er_ff[W-1:0];
               state_in = prh_pkg::ST_H_WR;
            end else begin
               h_ra = lm1_of_n(n_ff);
               state_in = prh_pkg::ST_H_RD;
            end
         end
         prh_pkg::ST_H_RD: begin
            mul_start = 1'b1;
            mret_in = prh_pkg::ST_H_ADD; state_in = prh_pkg::ST_MUL;
         end
         prh_pkg::ST_H_ADD: begin
            hv_in = (hsum >= {1'b0, prh_pkg::HASH_PRIME}) ?
                    W'(hsum - {1'b0, prh_pkg::HASH_PRIME}) : W'(hsum);
            state_in = prh_pkg::ST_H_WR;
         end
         prh_pkg::ST_H_WR: begin
            ha_we = !sel_ff; hb_we = sel_ff;
            if (sel_ff) len_b_in = n_ff + ONE;
            else len_a_in = n_ff + ONE;
            res_in = hv_ff;
            state_in = prh_pkg::ST_RESP;
         end
         prh_pkg::ST_MUL: begin
            if (!mul_busy) state_in = mret_ff;
         end
         prh_pkg::ST_SP0: begin
            h_ra = sp_r_ff[AW-1:0];
            state_in = prh_pkg::ST_SP1;
         end
         prh_pkg::ST_SP1: begin
            hr_in = h_rd;
            h_ra = lm1[AW-1:0];
            pw_ra = plen[AW-1:0];
            if (sp_l_ff == '0) begin
               span_in = h_rd;
               state_in = sret_ff;
            end else begin
               state_in = prh_pkg::ST_SP2;
            end
         end
         prh_pkg::ST_SP2: begin
            mul_start = 1'b1; mul_b = pw_rd;
            mret_in = prh_pkg::ST_SP3; state_in = prh_pkg::ST_MUL;
         end
         prh_pkg::ST_SP3: begin
            span_in = (hr_ff >= mul_p) ? hr_ff - mul_p :
                      hr_ff + (prh_pkg::HASH_PRIME - mul_p);
            state_in = sret_ff;
         end
         prh_pkg::ST_RG_FIN: begin
            res_in = span_ff;
            state_in = prh_pkg::ST_RESP;
         end
         prh_pkg::ST_CT_KEY: begin
            val1_in = span_ff; cnt_in = '0;
            sp_bank_in = sel_ff; sp_l_in = '0; sp_r_in = m_ff - ONE;
            sret_in = prh_pkg::ST_CT_CHK; state_in = prh_pkg::ST_SP0;
         end
         prh_pkg::ST_CT_CHK: begin
            if (span_ff == val1_ff) begin
               res_in = W'(1); state_in = prh_pkg::ST_RESP;
            end else if (cnt_ff == n_ff - m_ff) begin
               state_in = prh_pkg::ST_RESP;
            end else begin
               cnt_in = cnt_ff + ONE;
               sp_l_in = cnt_ff + ONE; sp_r_in = cnt_ff + m_ff;
               state_in = prh_pkg::ST_SP0;
            end
         end
         prh_pkg::ST_OV_B: begin
            val1_in = span_ff;
            sp_bank_in = sel_ff; sp_l_in = n_ff - cnt_ff; sp_r_in = n_ff - ONE;
            sret_in = prh_pkg::ST_OV_CHK; state_in = prh_pkg::ST_SP0;
         end
         prh_pkg::ST_OV_CHK: begin
            if (span_ff == val1_ff) begin
               res_in = W'(cnt_ff); state_in = prh_pkg::ST_RESP;
            end else if (cnt_ff == ONE) begin
               state_in = prh_pkg::ST_RESP;
            end else begin
               cnt_in = cnt_ff - ONE;
               sp_bank_in = !sel_ff; sp_l_in = '0; sp_r_in = cnt_ff - LW'(2);
               sret_in = prh_pkg::ST_OV_B; state_in = prh_pkg::ST_SP0;
            end
         end
         prh_pkg::ST_BS_TOP: begin
            if (lo_ff > hi_ff) begin
               res_in = W'(ans_ff); state_in = prh_pkg::ST_RESP;
            end else if (mid_w == '0) begin
               ans_in = '0; lo_in = BW'(1);
            end else begin
               mid_in = mid_w;
               sp_bank_in = !sel_ff;
               sp_l_in = (cmd_ff == prh_pkg::CMD_PREFIX) ? '0 : m_ff - mid_w;
               sp_r_in = (cmd_ff == prh_pkg::CMD_PREFIX) ? mid_w - ONE : m_ff - ONE;
               sret_in = prh_pkg::ST_BS_B; state_in = prh_pkg::ST_SP0;
            end
         end
         prh_pkg::ST_BS_B: begin
            val1_in = span_ff;
            sp_bank_in = sel_ff;
            sp_l_in = (cmd_ff == prh_pkg::CMD_PREFIX) ? '0 : n_ff - mid_ff;
            sp_r_in = (cmd_ff == prh_pkg::CMD_PREFIX) ? mid_ff - ONE : n_ff - ONE;
            sret_in = prh_pkg::ST_BS_CHK; state_in = prh_pkg::ST_SP0;
         end
         prh_pkg::ST_BS_CHK: begin
            if (span_ff == val1_ff) begin
               ans_in = BW'(mid_ff); lo_in = BW'(mid_ff) + BW'(1);
            end else begin
               hi_in = BW'(mid_ff) - BW'(1);
            end
            state_in = prh_pkg::ST_BS_TOP;
         end
         prh_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.result_value = res_ff;
               rsp_data_in.status = st_ff;
               state_in = prh_pkg::ST_IDLE;
            end
         end
         default: state_in = prh_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= prh_pkg::BASE_RESET;
         len_a_ff <= '0; len_b_ff <= '0; filled_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff <= base_in;
         len_a_ff <= len_a_in; len_b_ff <= len_b_in; filled_ff <= filled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sret_ff <= sret_in; mret_ff <= mret_in;
      cmd_ff <= cmd_in; sel_ff <= sel_in; sp_bank_ff <= sp_bank_in; er_ff <= er_in;
      rs_ff <= rs_in; re_ff <= re_in; n_ff <= n_in; m_ff <= m_in; cnt_ff <= cnt_in;
      sp_l_ff <= sp_l_in; sp_r_ff <= sp_r_in; mid_ff <= mid_in;
      lo_ff <= lo_in; hi_ff <= hi_in; ans_ff <= ans_in;
      hr_ff <= hr_in; span_ff <= span_in; val1_ff <= val1_in; hv_ff <= hv_in;
      res_ff <= res_in; st_ff <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   `PRH_NEVER(a_mul_restart, mul_start && mul_busy, "multiplier restarted while busy")
   `PRH_ASSERT(a_len_bound, len_a_ff <= LW'(MAX_LENGTH) && len_b_ff <= LW'(MAX_LENGTH), "bank overfull")
   `PRH_ASSERT(a_rsp_from_resp, $rose(rsp_valid_ff) |-> $past(state_ff == prh_pkg::ST_RESP), "result loaded outside response state")
   `PRH_NEVER(a_status_code, rsp_valid_ff && rsp_data_ff.status == 2'd3, "undefined status code")

endmodule
`default_nettype wire

>>> tb/tb_polynomial_rolling_hash_store.sv
// testbench of polynomial_rolling_hash_store: directed and random commands checked against
// a rolling hash predictor held in a small scoreboard class
// depends on prh_pkg and the rtl of the block only
`timescale 1ns / 100ps
`default_nettype none
module tb_polynomial_rolling_hash_store;

   localparam int unsigned BANK_DEPTH = prh_pkg::MAX_LENGTH_DEFAULT;
   localparam longint unsigned PRIME = longint'(prh_pkg::HASH_PRIME);
   localparam int unsigned CYCLE_LIMIT = 5000000;

   class hash_scoreboard;
      bit [prh_pkg::BASE_W-1:0] base;
      bit [prh_pkg::HASH_W-1:0] powers[BANK_DEPTH];
      int unsigned     powers_filled;
      bit [prh_pkg::HASH_W-1:0] prefix[2][BANK_DEPTH];
      int unsigned     len[2];
      prh_pkg::rsp_type pending[$];
      int              errors;

      function void set_base(bit [31:0] value);
         base = value[prh_pkg::BASE_W-1:0];
         powers_filled = 0;
         len[0] = 0;
         len[1] = 0;
      endfunction

      function longint unsigned mulmod(longint unsigned x, longint unsigned y);
         return (x * y) % PRIME;
      endfunction

      function longint unsigned span(int b, int unsigned l, int unsigned r);
         if (l == 0) return prefix[b][r];
         return (prefix[b][r] + PRIME - mulmod(prefix[b][l-1], powers[r-l+1])) % PRIME;
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         errors++;
         $display("mismatch: %s got %0d expected %0d", what, got, want);
      endtask

      function void note_request(prh_pkg::req_type q);
         int sel, oth, lo, hi, mid, ans;
         int unsigned n, m, mn, k;
         longint unsigned res, v, key;
         logic [1:0] st;
         sel = q.bank;
         oth = 1 - sel;
         n = len[sel];
         m = len[oth];
         mn = (n < m) ? n : m;
         res = 0;
         st = prh_pkg::STATUS_OK;
         case (q.command)
            prh_pkg::CMD_CLEAR: len[sel] = 0;
            prh_pkg::CMD_APPEND: begin
               if (n >= BANK_DEPTH) begin
                  st = prh_pkg::STATUS_FULL;
               end else begin
                  if (powers_filled <= n) begin
                     powers[n] = (n == 0) ? 1 : mulmod(powers[n-1], base);
                     powers_filled = n + 1;
                  end
                  v = longint'(q.element_value) % PRIME;
                  if (n > 0) v += mulmod(prefix[sel][n-1], base);
                  prefix[sel][n] = v % PRIME;
                  len[sel] = n + 1;
                  res = prefix[sel][n];
               end
            end
            prh_pkg::CMD_RANGE: begin
               if (q.range_start > q.range_end || q.range_end >= n)
                  st = prh_pkg::STATUS_RANGE;
               else res = span(sel, q.range_start, q.range_end);
            end
            prh_pkg::CMD_KEY: res = (n == 0) ? 0 : prefix[sel][n-1];
            prh_pkg::CMD_CONTAINS: begin
               if (m == 0) begin
                  res = 1;
               end else if (n >= m) begin
                  key = prefix[oth][m-1];
                  for (int unsigned i = 0; i <= n - m; i++) begin
                     if (span(sel, i, i + m - 1) == key) begin
                        res = 1;
                        break;
                     end
                  end
               end
            end
            prh_pkg::CMD_OVERLAP: begin
               for (k = mn; k >= 1; k--) begin
                  if (span(sel, n - k, n - 1) == span(oth, 0, k - 1)) begin
                     res = k;
                     break;
                  end
               end
            end
            default: begin
               lo = 0;
               hi = mn;
               ans = 0;
               while (lo <= hi) begin
                  bit eq;
                  mid = (lo + hi) / 2;
                  if (mid == 0) eq = 1;
                  else if (q.command == prh_pkg::CMD_PREFIX)
                     eq = span(sel, 0, mid - 1) == span(oth, 0, mid - 1);
                  else
                     eq = span(sel, n - mid, n - 1) == span(oth, m - mid, m - 1);
                  if (eq) begin
                     ans = mid;
                     lo = mid + 1;
                  end else begin
                     hi = mid - 1;
                  end
               end
               res = ans;
            end
         endcase
         pending.push_back('{result_value: res[prh_pkg::HASH_W-1:0], status: st});
      endfunction

      task check_result(prh_pkg::rsp_type r);
         prh_pkg::rsp_type want;
         if (pending.size() == 0) begin
            report("result with nothing pending, value", r.result_value, 0);
         end else begin
            want = pending.pop_front();
            if (r.result_value !== want.result_value)
               report("result_value", r.result_value, want.result_value);
            if (r.status !== want.status) report("status", r.status, want.status);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   prh_pkg::req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   prh_pkg::rsp_type rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hash_scoreboard sb;
   int unsigned    cycles;
   int unsigned    burst_left;
   int unsigned    stall_left;
   int unsigned    stall_mode;

   polynomial_rolling_hash_store u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("polynomial_rolling_hash_store test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall = 1'b0;
         1: rsp_stall = ($urandom_range(0, 3) == 0);
         2: rsp_stall = $urandom_range(0, 1);
         default: rsp_stall = (stall_left > 40);
      endcase
   end

   // called and returns at a falling edge
   task send_item(prh_pkg::req_type q);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 20) : $urandom_range(0, 4))
            @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid = 1'b1;
      req_data = q;
      do @(posedge clock); while (req_stall);
      sb.note_request(q);
      @(negedge clock);
   endtask

   task drain;
      req_valid = 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task write_base(bit [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = {prh_pkg::REG_HASH_BASE, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_base(value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function prh_pkg::req_type make_req(logic [2:0] cmd, logic bank, logic [31:0] elem,
                                       logic [9:0] rs, logic [9:0] re);
      return '{command: cmd, bank: bank, element_value: elem, range_start: rs, range_end: re};
   endfunction

   function prh_pkg::req_type random_req;
      prh_pkg::req_type q;
      int unsigned r, n;
      q = '{command: $urandom_range(0, 7), bank: $urandom_range(0, 1),
            element_value: $urandom, range_start: $urandom_range(0, 1023),
            range_end: $urandom_range(0, 1023)};
      n = sb.len[q.bank];
      r = $urandom_range(0, 99);
      if (r < 38) q.command = prh_pkg::CMD_APPEND;
      else if (r < 43) q.command = prh_pkg::CMD_CLEAR;
      else if (r < 55) q.command = prh_pkg::CMD_RANGE;
      else if (r < 62) q.command = prh_pkg::CMD_KEY;
      else if (r < 72) q.command = prh_pkg::CMD_CONTAINS;
      else if (r < 80) q.command = prh_pkg::CMD_OVERLAP;
      else if (r < 90) q.command = prh_pkg::CMD_PREFIX;
      else q.command = prh_pkg::CMD_SUFFIX;
      // keep banks short so that comparisons stay cheap
      if (q.command == prh_pkg::CMD_APPEND && n >= 12)
         q.command = $urandom_range(0, 1) ? prh_pkg::CMD_CLEAR : prh_pkg::CMD_RANGE;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: q.element_value = $urandom_range(0, 2);
         6: q.element_value = $urandom;
         7: q.element_value = 32'(PRIME) - 1 + $urandom_range(0, 2);
         8: q.element_value = 32'hFFFF_FFFF - $urandom_range(0, 1);
         default: q.element_value = 32'(PRIME) + $urandom_range(0, 2);
      endcase
      if (n > 0 && $urandom_range(0, 4) != 0) begin
         q.range_start = $urandom_range(0, n - 1);
         q.range_end = $urandom_range(q.range_start, n - 1);
      end
      return q;
   endfunction

   initial begin
      sb = new();
      sb.set_base(32'(prh_pkg::BASE_RESET));
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty banks, edge values, bad ranges, every command
      send_item(make_req(prh_pkg::CMD_KEY, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_CONTAINS, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_OVERLAP, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_PREFIX, 1, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_SUFFIX, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_APPEND, 0, 32'hFFFF_FFFF, 10'h3FF, 10'h3FF));
      send_item(make_req(prh_pkg::CMD_APPEND, 0, 32'(PRIME), 0, 0));
      send_item(make_req(prh_pkg::CMD_APPEND, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_APPEND, 1, 32'hFFFF_FFFF, 0, 0));
      send_item(make_req(prh_pkg::CMD_APPEND, 1, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 0, 2));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 1, 2));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 2, 1));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 0, 3));
      send_item(make_req(prh_pkg::CMD_KEY, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_CONTAINS, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_CONTAINS, 1, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_OVERLAP, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_PREFIX, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_SUFFIX, 1, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_CLEAR, 1, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_KEY, 1, 0, 0, 0));
      drain();

      // fill one bank to the top with base 1000000, the largest base that the test writes
      write_base(32'd1000000);
      send_item(make_req(prh_pkg::CMD_APPEND, 1, 7, 0, 0));
      send_item(make_req(prh_pkg::CMD_APPEND, 1, 9, 0, 0));
      for (int i = 0; i < BANK_DEPTH; i++)
         send_item(make_req(prh_pkg::CMD_APPEND, 0, (i % 3 == 0) ? 7 : $urandom, 0, 0));
      send_item(make_req(prh_pkg::CMD_APPEND, 0, 5, 0, 0));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 0, 10'h3FF));
      send_item(make_req(prh_pkg::CMD_RANGE, 0, 0, 1, 10'h3FF));
      send_item(make_req(prh_pkg::CMD_KEY, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_CONTAINS, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_OVERLAP, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_PREFIX, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_SUFFIX, 0, 0, 0, 0));
      send_item(make_req(prh_pkg::CMD_CLEAR, 0, 0, 0, 0));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_base(32'(prh_pkg::BASE_RESET));
            1: write_base(32'd1000000);
            default: write_base($urandom_range(257, 1000000));
         endcase
         for (int i = 0; i < 75; i++) send_item(random_req());
         drain();
      end

      if (sb.errors == 0) $display("polynomial_rolling_hash_store test passed");
      else $display("polynomial_rolling_hash_store test failed");
      $finish;
   end
endmodule
`default_nettype wire
